// ----- hdl/lnbx_pkg.sv -----
// ----------------------------------------------------------------------------
// lnbx_pkg
// Shared types and constants of the letterbox nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package lnbx_pkg;

  localparam int COORD_W    = 10;
  localparam int PIX_W      = 32;
  localparam int SRC_REG_W  = 9;
  localparam int DST_REG_W  = 11;
  localparam int CFG_IDX_W  = 3;

  localparam logic [SRC_REG_W-1:0] SRC_SIZE_RST = 9'd256;
  localparam logic [DST_REG_W-1:0] DST_SIZE_RST = 11'd1024;
  localparam logic [PIX_W-1:0]     PAD_RST      = 32'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_W = 3'd0,
    CFG_SRC_H = 3'd1,
    CFG_DST_W = 3'd2,
    CFG_DST_H = 3'd3,
    CFG_PAD   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic empty;
  } geom_stat_t;

endpackage

// ----- hdl/lnbx_ram.sv -----
// ----------------------------------------------------------------------------
// lnbx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lnbx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/lnbx_geom.sv -----
// ----------------------------------------------------------------------------
// lnbx_geom
// Configuration registers and the fitted-area calculation. After reset or a
// register write, a sequencer clamps the sizes, cross-multiplies, runs a
// bit-serial divider and derives the centered bounds.
// ----------------------------------------------------------------------------
module lnbx_geom #(
  parameter int MAX_SRC_W = 256,
  parameter int MAX_SRC_H = 256,
  parameter int MAX_DST_W = 1024,
  parameter int MAX_DST_H = 1024,
  localparam int SW = $clog2(MAX_SRC_W + 1),
  localparam int SH = $clog2(MAX_SRC_H + 1),
  localparam int TW = $clog2(MAX_DST_W + 1),
  localparam int TH = $clog2(MAX_DST_H + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lnbx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lnbx_pkg::PIX_W-1:0]     cfg_data,
  output logic [SW-1:0]                  src_w,
  output logic [SH-1:0]                  src_h,
  output logic [TW-1:0]                  fit_w,
  output logic [TH-1:0]                  fit_h,
  output logic [TW-1:0]                  x_lo,
  output logic [TW-1:0]                  x_hi,
  output logic [TH-1:0]                  y_lo,
  output logic [TH-1:0]                  y_hi,
  output logic [lnbx_pkg::PIX_W-1:0]     pad_color,
  output lnbx_pkg::geom_stat_t           stat
);

  localparam int PW  = (SW + TH > TW + SH) ? SW + TH : TW + SH;
  localparam int DNW = (SW > SH) ? SW : SH;
  localparam int CNW = $clog2(PW + 1);

  typedef enum logic [4:0] {
    GS_IDLE  = 5'b00001,
    GS_LOAD  = 5'b00010,
    GS_MUL   = 5'b00100,
    GS_DIV   = 5'b01000,
    GS_BOUND = 5'b10000
  } gstate_t;

  function automatic int clamp_sz(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  gstate_t state_r, state_nxt;

  logic [lnbx_pkg::SRC_REG_W-1:0] reg_sw_r, reg_sh_r;
  logic [lnbx_pkg::DST_REG_W-1:0] reg_tw_r, reg_th_r;
  logic [lnbx_pkg::PIX_W-1:0]     pad_r;

  logic [SW-1:0]  sw_r;
  logic [SH-1:0]  sh_r;
  logic [TW-1:0]  tw_r;
  logic [TH-1:0]  th_r;
  logic           wide_r;
  logic [PW-1:0]  num_r;
  logic [DNW-1:0] den_r;
  logic [DNW:0]   rem_r;
  logic [PW-1:0]  quo_r;
  logic [CNW-1:0] cnt_r;
  logic [TW-1:0]  fw_r, x0_r, x1_r;
  logic [TH-1:0]  fh_r, y0_r, y1_r;
  logic           empty_r;

  logic [DNW:0]   shift_c;
  logic           ge_c;
  logic [TW-1:0]  fw_c;
  logic [TH-1:0]  fh_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_sw_r <= lnbx_pkg::SRC_SIZE_RST;
      reg_sh_r <= lnbx_pkg::SRC_SIZE_RST;
      reg_tw_r <= lnbx_pkg::DST_SIZE_RST;
      reg_th_r <= lnbx_pkg::DST_SIZE_RST;
      pad_r    <= lnbx_pkg::PAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lnbx_pkg::CFG_SRC_W: reg_sw_r <= cfg_data[lnbx_pkg::SRC_REG_W-1:0];
        lnbx_pkg::CFG_SRC_H: reg_sh_r <= cfg_data[lnbx_pkg::SRC_REG_W-1:0];
        lnbx_pkg::CFG_DST_W: reg_tw_r <= cfg_data[lnbx_pkg::DST_REG_W-1:0];
        lnbx_pkg::CFG_DST_H: reg_th_r <= cfg_data[lnbx_pkg::DST_REG_W-1:0];
        lnbx_pkg::CFG_PAD:   pad_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      GS_IDLE:  state_nxt = GS_IDLE;
      GS_LOAD:  state_nxt = GS_MUL;
      GS_MUL:   state_nxt = GS_DIV;
      GS_DIV:   state_nxt = (cnt_r == CNW'(1)) ? GS_BOUND : GS_DIV;
      GS_BOUND: state_nxt = GS_IDLE;
      default:  state_nxt = GS_LOAD;
    endcase
    // restart on any register write
    if (cfg_we) state_nxt = GS_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= GS_LOAD;
    else        state_r <= state_nxt;
  end

  assign shift_c = {rem_r[DNW-1:0], num_r[PW-1]};
  assign ge_c    = shift_c >= (DNW+1)'(den_r);

  always_comb begin
    if (wide_r) begin
      fw_c = tw_r;
      fh_c = quo_r[TH-1:0];
    end else begin
      fw_c = quo_r[TW-1:0];
      fh_c = th_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      GS_LOAD: begin
        sw_r <= SW'(clamp_sz(int'(reg_sw_r), MAX_SRC_W));
        sh_r <= SH'(clamp_sz(int'(reg_sh_r), MAX_SRC_H));
        tw_r <= TW'(clamp_sz(int'(reg_tw_r), MAX_DST_W));
        th_r <= TH'(clamp_sz(int'(reg_th_r), MAX_DST_H));
      end
      GS_MUL: begin
        wide_r <= (PW'(sw_r) * PW'(th_r)) > (PW'(tw_r) * PW'(sh_r));
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= CNW'(PW);
        if ((PW'(sw_r) * PW'(th_r)) > (PW'(tw_r) * PW'(sh_r))) begin
          num_r <= PW'(tw_r) * PW'(sh_r);
          den_r <= DNW'(sw_r);
        end else begin
          num_r <= PW'(sw_r) * PW'(th_r);
          den_r <= DNW'(sh_r);
        end
      end
      GS_DIV: begin
        rem_r <= ge_c ? shift_c - (DNW+1)'(den_r) : shift_c;
        num_r <= num_r << 1;
        quo_r <= {quo_r[PW-2:0], ge_c};
        cnt_r <= cnt_r - CNW'(1);
      end
      GS_BOUND: begin
        fw_r    <= fw_c;
        fh_r    <= fh_c;
        x0_r    <= TW'((tw_r - fw_c) >> 1);
        x1_r    <= TW'(((TW+1)'(tw_r) + (TW+1)'(fw_c)) >> 1);
        y0_r    <= TH'((th_r - fh_c) >> 1);
        y1_r    <= TH'(((TH+1)'(th_r) + (TH+1)'(fh_c)) >> 1);
        empty_r <= (fw_c == '0) || (fh_c == '0);
      end
      default: ;
    endcase
  end

  assign src_w      = sw_r;
  assign src_h      = sh_r;
  assign fit_w      = fw_r;
  assign fit_h      = fh_r;
  assign x_lo       = x0_r;
  assign x_hi       = x1_r;
  assign y_lo       = y0_r;
  assign y_hi       = y1_r;
  assign pad_color  = pad_r;
  assign stat.busy  = (state_r != GS_IDLE);
  assign stat.empty = empty_r;

endmodule

// ----- hdl/lnbx_div2.sv -----
// ----------------------------------------------------------------------------
// lnbx_div2
// Two-lane pipelined restoring divider, one quotient bit per stage, with a
// sideband word alongside. The user holds divisors steady; the block won't check.
// ----------------------------------------------------------------------------
module lnbx_div2 #(
  parameter int NW  = 20,
  parameter int DW  = 11,
  parameter int QW  = 8,
  parameter int SBW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [NW-1:0]  num_x,
  input  logic [NW-1:0]  num_y,
  input  logic [DW-1:0]  den_x,
  input  logic [DW-1:0]  den_y,
  input  logic [SBW-1:0] sb_in,
  output logic           out_v,
  output logic [QW-1:0]  q_x,
  output logic [QW-1:0]  q_y,
  output logic [SBW-1:0] sb_out
);

  localparam int CW = NW + QW;

  logic [NW-1:0]  num_in [2];
  logic [DW-1:0]  den_in [2];
  logic [NW-1:0]  rem_r  [QW][2];
  logic [QW-1:0]  quo_r  [QW][2];
  logic [SBW-1:0] sb_r   [QW];
  logic [QW-1:0]  v_r;

  assign num_in[0] = num_x;
  assign num_in[1] = num_y;
  assign den_in[0] = den_x;
  assign den_in[1] = den_y;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic           vin;
    logic [SBW-1:0] sbin;

    if (k == 0) begin : g_first
      assign vin  = in_v;
      assign sbin = sb_in;
    end else begin : g_next
      assign vin  = v_r[k-1];
      assign sbin = sb_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n)  v_r[k] <= 1'b0;
      else if (en) v_r[k] <= vin;
    end

    always_ff @(posedge clk) begin
      if (en) sb_r[k] <= sbin;
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [NW-1:0] rin;
      logic [QW-1:0] qin;
      logic [CW-1:0] trial;
      logic          ge;

      if (k == 0) begin : g_first
        assign rin = num_in[l];
        assign qin = '0;
      end else begin : g_next
        assign rin = rem_r[k-1][l];
        assign qin = quo_r[k-1][l];
      end

      assign trial = CW'(den_in[l]) << B;
      assign ge    = CW'(rin) >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= ge ? NW'(CW'(rin) - trial) : rin;
          quo_r[k][l] <= qin | (ge ? (QW'(1) << B) : QW'(0));
        end
      end
    end
  end

  assign out_v  = v_r[QW-1];
  assign q_x    = quo_r[QW-1][0];
  assign q_y    = quo_r[QW-1][1];
  assign sb_out = sb_r[QW-1];

  // final remainders are not needed
  logic unused_rem;
  assign unused_rem = ^{rem_r[QW-1][0], rem_r[QW-1][1]};

endmodule

// ----- hdl/letterbox_nearest_scaler_unit.sv -----
// ----------------------------------------------------------------------------
// letterbox_nearest_scaler_unit
// Aspect-preserving nearest-neighbor scaler with letterbox padding.
// ----------------------------------------------------------------------------
// One word enters per clock while in_ready is high, writes and requests alike.
// A request passes a bounds stage, a multiply stage, Q divider stages and the
// registered read of the source memory, where Q = clog2(MAX(MAX_SRC_W,
// MAX_SRC_H)) is the number of stages of the pipelined coordinate divider (8
// at default sizes). Writes produce no answer. After reset and after each
// register write the fitted geometry is recomputed by a bit-serial divider of
// P quotient bits (P = 20 at default sizes), which holds in_ready low until it
// is done. The source store has no reset: read only pixels that were written.
// ----------------------------------------------------------------------------
module letterbox_nearest_scaler_unit #(
  parameter int MAX_SRC_W = 256,
  parameter int MAX_SRC_H = 256,
  parameter int MAX_DST_W = 1024,
  parameter int MAX_DST_H = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [lnbx_pkg::COORD_W-1:0]   in_coord_x,
  input  logic [lnbx_pkg::COORD_W-1:0]   in_coord_y,
  input  logic [lnbx_pkg::PIX_W-1:0]     in_write_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lnbx_pkg::PIX_W-1:0]     out_pixel,
  output logic                           out_is_padding,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lnbx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lnbx_pkg::PIX_W-1:0]     cfg_data
);

  localparam int SW    = $clog2(MAX_SRC_W + 1);
  localparam int SH    = $clog2(MAX_SRC_H + 1);
  localparam int TW    = $clog2(MAX_DST_W + 1);
  localparam int TH    = $clog2(MAX_DST_H + 1);
  localparam int QXW   = $clog2(MAX_SRC_W);
  localparam int QYW   = $clog2(MAX_SRC_H);
  localparam int QW    = (QXW > QYW) ? ((QXW > 1) ? QXW : 1) : ((QYW > 1) ? QYW : 1);
  localparam int NW    = (TW + SW > TH + SH) ? TW + SW : TH + SH;
  localparam int DW    = (TW > TH) ? TW : TH;
  localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CRW   = (TW > TH) ? TW : TH;
  localparam int CW    = ((CRW > lnbx_pkg::COORD_W) ? CRW : lnbx_pkg::COORD_W) + 1;
  localparam int PXW   = lnbx_pkg::PIX_W;
  localparam int SBW   = 3 + AW + PXW;

  // geometry
  logic [SW-1:0]        src_w;
  logic [SH-1:0]        src_h;
  logic [TW-1:0]        fit_w, x_lo, x_hi;
  logic [TH-1:0]        fit_h, y_lo, y_hi;
  logic [PXW-1:0]       pad_color;
  lnbx_pkg::geom_stat_t gstat;

  logic en, in_acc;

  assign cfg_ready = rst_n;

  lnbx_geom #(
    .MAX_SRC_W(MAX_SRC_W), .MAX_SRC_H(MAX_SRC_H),
    .MAX_DST_W(MAX_DST_W), .MAX_DST_H(MAX_DST_H)
  ) u_geom (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .src_w(src_w), .src_h(src_h), .fit_w(fit_w), .fit_h(fit_h),
    .x_lo(x_lo), .x_hi(x_hi), .y_lo(y_lo), .y_hi(y_hi),
    .pad_color(pad_color), .stat(gstat)
  );

  // stage 1: bounds, offsets, store address for writes
  logic [CW-1:0] cx, cy;
  logic          inside_c, in_store_c;

  assign cx = CW'(in_coord_x);
  assign cy = CW'(in_coord_y);
  assign inside_c = !gstat.empty &&
                    (cx >= CW'(x_lo)) && (cx < CW'(x_hi)) &&
                    (cy >= CW'(y_lo)) && (cy < CW'(y_hi));
  assign in_store_c = (int'(in_coord_x) < MAX_SRC_W) && (int'(in_coord_y) < MAX_SRC_H);

  logic           v1_r, op1_r, pad1_r, we1_r;
  logic [AW-1:0]  wa1_r;
  logic [PXW-1:0] wd1_r;
  logic [TW-1:0]  dx1_r;
  logic [TH-1:0]  dy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  v1_r <= 1'b0;
    else if (en) v1_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= in_op;
      pad1_r <= !inside_c;
      we1_r  <= !in_op && in_store_c;
      wa1_r  <= AW'(int'(in_coord_y) * MAX_SRC_W + int'(in_coord_x));
      wd1_r  <= in_write_pixel;
      dx1_r  <= TW'(cx - CW'(x_lo));
      dy1_r  <= TH'(cy - CW'(y_lo));
    end
  end

  // stage 2: scale offsets by the source size
  logic           v2_r;
  logic [SBW-1:0] sb2_r;
  logic [NW-1:0]  nx2_r, ny2_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_r <= {op1_r, pad1_r, we1_r, wa1_r, wd1_r};
      nx2_r <= NW'(dx1_r) * NW'(src_w);
      ny2_r <= NW'(dy1_r) * NW'(src_h);
    end
  end

  // stages 3..Q+2: divide by the fitted size
  logic           vd;
  logic [QW-1:0]  qx, qy;
  logic [SBW-1:0] sbd;

  lnbx_div2 #(.NW(NW), .DW(DW), .QW(QW), .SBW(SBW)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(v2_r),
    .num_x(nx2_r), .num_y(ny2_r), .den_x(DW'(fit_w)), .den_y(DW'(fit_h)),
    .sb_in(sb2_r), .out_v(vd), .q_x(qx), .q_y(qy), .sb_out(sbd)
  );

  logic           d_op, d_pad, d_we;
  logic [AW-1:0]  d_wa;
  logic [PXW-1:0] d_wd;
  int             sx_c, sy_c;
  logic [AW-1:0]  ra_c;
  logic           ram_we, ram_re;
  logic [PXW-1:0] ram_rd;

  assign {d_op, d_pad, d_we, d_wa, d_wd} = sbd;

  always_comb begin
    sx_c = (int'(qx) > MAX_SRC_W - 1) ? MAX_SRC_W - 1 : int'(qx);
    sy_c = (int'(qy) > MAX_SRC_H - 1) ? MAX_SRC_H - 1 : int'(qy);
    ra_c = AW'(sy_c * MAX_SRC_W + sx_c);
  end

  assign ram_we = en && vd && d_we;
  assign ram_re = en && vd && d_op && !d_pad;

  lnbx_ram #(.WIDTH(PXW), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(ram_we), .waddr(d_wa), .wdata(d_wd),
    .re(ram_re), .raddr(ra_c), .rdata(ram_rd)
  );

  // output stage: memory read register plus result flags
  logic ov_r, opad_r;

  always_ff @(posedge clk) begin
    if (!rst_n)  ov_r <= 1'b0;
    else if (en) ov_r <= vd && d_op;
  end

  always_ff @(posedge clk) begin
    if (en) opad_r <= d_pad;
  end

  // advance the whole pipe unless a result is held
  assign en             = !ov_r || out_ready;
  assign in_ready       = en && !gstat.busy && rst_n;
  assign in_acc         = in_valid && in_ready;
  assign out_valid      = ov_r;
  assign out_pixel      = opad_r ? pad_color : ram_rd;
  assign out_is_padding = opad_r;

  a_fit_span: assert property (@(posedge clk) disable iff (!rst_n)
    !gstat.busy |-> (TW'(x_hi - x_lo) == fit_w) && (TH'(y_hi - y_lo) == fit_h))
    else $error("fitted bounds do not span the fitted size");

  a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store written and read by one stage");

  a_src_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vd && d_op && !d_pad && !gstat.busy) |-> (int'(qx) < int'(src_w)) &&
                                             (int'(qy) < int'(src_h)))
    else $error("source coordinate beyond configured size");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    gstat.busy |=> !v1_r || $past(!gstat.busy))
    else $error("word accepted while geometry recomputes");

endmodule

// ----- tb/letterbox_nearest_scaler_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// letterbox_nearest_scaler_unit_tb
// Drives source-pixel writes and target-pixel requests through several
// geometry settings and checks each answer against an in-bench letterbox-fit
// predictor or table value, with bursty input and a stalling result receiver.
// ----------------------------------------------------------------------------
module letterbox_nearest_scaler_unit_tb;

  localparam int SRC_MAX_W = 256;
  localparam int SRC_MAX_H = 256;
  localparam int DST_MAX_W = 1024;
  localparam int DST_MAX_H = 1024;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;
  localparam logic [lnbx_pkg::CFG_IDX_W-1:0] CFG_UNKNOWN = 3'd7;

  typedef struct {
    logic [lnbx_pkg::PIX_W-1:0] pixel;
    logic                       pad;
  } px_result_t;

  typedef struct {
    logic                       op;
    int unsigned                x;
    int unsigned                y;
    logic [lnbx_pkg::PIX_W-1:0] pix;
    bit                         typed;
    logic [lnbx_pkg::PIX_W-1:0] exp_pix;
    logic                       exp_pad;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_op;
  logic [lnbx_pkg::COORD_W-1:0] in_coord_x, in_coord_y;
  logic [lnbx_pkg::PIX_W-1:0] in_write_pixel;
  logic out_valid, out_ready, out_is_padding;
  logic [lnbx_pkg::PIX_W-1:0] out_pixel;
  logic cfg_valid, cfg_ready;
  logic [lnbx_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lnbx_pkg::PIX_W-1:0] cfg_data;

  letterbox_nearest_scaler_unit uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [lnbx_pkg::SRC_REG_W-1:0] geo_sw, geo_sh;
  logic [lnbx_pkg::DST_REG_W-1:0] geo_tw, geo_th;
  logic [lnbx_pkg::PIX_W-1:0]     geo_pad;
  logic [lnbx_pkg::PIX_W-1:0]     src_mem [SRC_MAX_W*SRC_MAX_H];
  bit                             src_written [SRC_MAX_W*SRC_MAX_H];
  px_result_t                     pending_px[$];

  int mismatches = 0;
  int n_writes = 0, n_reads = 0, n_pads = 0, n_checked = 0, n_phases = 0;
  int burst_left = 0;

  function automatic longint unsigned clamp_dim(longint unsigned v, longint unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Returns 1 when (x,y) lands in the fitted area; addr is the source word.
  function automatic bit fit_lookup(input int unsigned x, input int unsigned y,
                                    output int unsigned addr);
    longint unsigned sw, sh, tw, th, fw, fh, x0, x1, y0, y1, sx, sy;
    sw = clamp_dim(geo_sw, SRC_MAX_W);
    sh = clamp_dim(geo_sh, SRC_MAX_H);
    tw = clamp_dim(geo_tw, DST_MAX_W);
    th = clamp_dim(geo_th, DST_MAX_H);
    if (sw * th > tw * sh) begin
      fw = tw;
      fh = (tw * sh) / sw;
    end else begin
      fh = th;
      fw = (th * sw) / sh;
    end
    x0 = (tw - fw) / 2;
    x1 = (tw + fw) / 2;
    y0 = (th - fh) / 2;
    y1 = (th + fh) / 2;
    addr = 0;
    if (fw == 0 || fh == 0 || x < x0 || x >= x1 || y < y0 || y >= y1) return 1'b0;
    sx = ((x - x0) * sw) / fw;
    sy = ((y - y0) * sh) / fh;
    if (sx >= SRC_MAX_W) sx = SRC_MAX_W - 1;
    if (sy >= SRC_MAX_H) sy = SRC_MAX_H - 1;
    addr = 32'(sy * SRC_MAX_W + sx);
    return 1'b1;
  endfunction

  task automatic send_word(logic op, int unsigned x, int unsigned y,
                           logic [lnbx_pkg::PIX_W-1:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_op          <= op;
    in_coord_x     <= x[lnbx_pkg::COORD_W-1:0];
    in_coord_y     <= y[lnbx_pkg::COORD_W-1:0];
    in_write_pixel <= pix;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send one word, update the store model and queue the expected answer.
  task automatic issue(logic op, int unsigned x, int unsigned y,
                       logic [lnbx_pkg::PIX_W-1:0] pix, bit typed = 0,
                       logic [lnbx_pkg::PIX_W-1:0] t_pix = '0, logic t_pad = 1'b0);
    px_result_t r;
    int unsigned addr;
    bit hit;
    send_word(op, x, y, pix);
    if (op == OP_WRITE) begin
      n_writes++;
      if (x < SRC_MAX_W && y < SRC_MAX_H) begin
        src_mem[y*SRC_MAX_W + x]     = pix;
        src_written[y*SRC_MAX_W + x] = 1'b1;
      end
    end else begin
      n_reads++;
      hit = fit_lookup(x, y, addr);
      r.pixel = hit ? src_mem[addr] : geo_pad;
      r.pad   = !hit;
      if (typed) begin
        r.pixel = t_pix;
        r.pad   = t_pad;
      end
      if (r.pad) n_pads++;
      pending_px.push_back(r);
    end
  endtask

  // Request a target pixel; fill its source word first if never written.
  task automatic request_px(int unsigned x, int unsigned y);
    int unsigned addr;
    if (fit_lookup(x, y, addr) && !src_written[addr])
      issue(OP_WRITE, addr % SRC_MAX_W, addr / SRC_MAX_W, $urandom);
    issue(OP_READ, x, y, $urandom);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    // writes may still be in flight
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [lnbx_pkg::CFG_IDX_W-1:0] idx,
                           logic [lnbx_pkg::PIX_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lnbx_pkg::CFG_SRC_W: geo_sw  = data[lnbx_pkg::SRC_REG_W-1:0];
      lnbx_pkg::CFG_SRC_H: geo_sh  = data[lnbx_pkg::SRC_REG_W-1:0];
      lnbx_pkg::CFG_DST_W: geo_tw  = data[lnbx_pkg::DST_REG_W-1:0];
      lnbx_pkg::CFG_DST_H: geo_th  = data[lnbx_pkg::DST_REG_W-1:0];
      lnbx_pkg::CFG_PAD:   geo_pad = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [lnbx_pkg::PIX_W-1:0] sw, logic [lnbx_pkg::PIX_W-1:0] sh,
                              logic [lnbx_pkg::PIX_W-1:0] tw, logic [lnbx_pkg::PIX_W-1:0] th,
                              logic [lnbx_pkg::PIX_W-1:0] pad);
    drain_wait();
    write_reg(lnbx_pkg::CFG_SRC_W, sw);
    write_reg(lnbx_pkg::CFG_SRC_H, sh);
    write_reg(lnbx_pkg::CFG_DST_W, tw);
    write_reg(lnbx_pkg::CFG_DST_H, th);
    write_reg(lnbx_pkg::CFG_PAD, pad);
    n_phases++;
  endtask

  task automatic random_items(int count);
    int unsigned tw, th, sw, sh;
    sw = 32'(clamp_dim(geo_sw, SRC_MAX_W));
    sh = 32'(clamp_dim(geo_sh, SRC_MAX_H));
    tw = 32'(clamp_dim(geo_tw, DST_MAX_W));
    th = 32'(clamp_dim(geo_th, DST_MAX_H));
    if (tw > 1024) tw = 1024;
    if (th > 1024) th = 1024;
    repeat (count) begin
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 9) < 7)
          issue(OP_WRITE, $urandom_range(0, sw-1), $urandom_range(0, sh-1), $urandom);
        else
          issue(OP_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
      end else if ($urandom_range(0, 9) < 8) begin
        request_px($urandom_range(0, tw-1), $urandom_range(0, th-1));
      end else begin
        request_px($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
    end
  endtask

  // result receiver: shifting stall pattern plus two long hold-offs taken
  // while requests are still streaming in
  int unsigned rx_cycle = 0, rx_hold = 0, rx_mode = 0;
  int hold_at = 40;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_at != 0 && n_reads >= hold_at) begin
      rx_hold = 400;
      hold_at = (hold_at == 40) ? 300 : 0;
    end
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    px_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: pixel=%h pad=%b", out_pixel, out_is_padding);
      end else begin
        e = pending_px.pop_front();
        n_checked++;
        if (out_pixel !== e.pixel || out_is_padding !== e.pad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pixel=%h pad=%b, got pixel=%h pad=%b",
                     e.pixel, e.pad, out_pixel, out_is_padding);
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  dir_row_t dir_rows [13] = '{
    '{OP_WRITE,    0,    0, 32'hFFFF_FFFF, 0, '0, 1'b0},
    '{OP_WRITE,  255,  255, 32'h0000_0000, 0, '0, 1'b0},
    '{OP_WRITE,  255,    0, 32'hA5A5_A5A5, 0, '0, 1'b0},
    '{OP_WRITE,    0,  255, 32'h5A5A_5A5A, 0, '0, 1'b0},
    // outside the store: drop
    '{OP_WRITE, 1023,    0, 32'h1234_5678, 0, '0, 1'b0},
    '{OP_WRITE,    0, 1023, 32'h8765_4321, 0, '0, 1'b0},
    '{OP_WRITE,  256,  256, 32'hDEAD_BEEF, 0, '0, 1'b0},
    '{OP_READ,     0,    0, 32'h0, 1, 32'hFFFF_FFFF, 1'b0},
    '{OP_READ,  1023, 1023, 32'h0, 1, 32'h0000_0000, 1'b0},
    '{OP_READ,  1023,    0, 32'h0, 1, 32'hA5A5_A5A5, 1'b0},
    '{OP_READ,     0, 1023, 32'h0, 1, 32'h5A5A_5A5A, 1'b0},
    '{OP_READ,     3,    3, 32'h0, 1, 32'hFFFF_FFFF, 1'b0},
    '{OP_READ,  1020, 1021, 32'h0, 0, '0, 1'b0}
  };

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0; in_op = OP_WRITE; in_coord_x = '0; in_coord_y = '0;
    in_write_pixel = '0; out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = lnbx_pkg::CFG_SRC_W; cfg_data = '0;
    geo_sw = lnbx_pkg::SRC_SIZE_RST; geo_sh = lnbx_pkg::SRC_SIZE_RST;
    geo_tw = lnbx_pkg::DST_SIZE_RST; geo_th = lnbx_pkg::DST_SIZE_RST;
    geo_pad = lnbx_pkg::PAD_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      issue(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].pix,
            dir_rows[i].typed, dir_rows[i].exp_pix, dir_rows[i].exp_pad);
    n_phases++;
    random_items(100);

    // wide source into a tiny target: fitted height floors to zero
    set_geometry(256, 1, 1, 1024, 32'hFFFF_FFFF);
    request_px(0, 0);
    request_px(0, 512);
    random_items(60);
    // zero sizes act as one
    set_geometry(0, 0, 0, 0, 32'h0F0F_F0F0);
    request_px(0, 0);
    request_px(1, 0);
    random_items(60);
    set_geometry(1, 1, 1024, 1, 32'h1357_9BDF);
    random_items(100);
    // oversized registers saturate
    set_geometry(511, 300, 2047, 2000, 32'hCAFE_0001);
    write_reg(CFG_UNKNOWN, 32'h0000_0001);
    random_items(100);
    set_geometry(3, 7, 50, 40, 32'h8000_0001);
    random_items(100);
    repeat (3) begin
      set_geometry($urandom_range(1, 32), $urandom_range(1, 32),
                   $urandom_range(1, 64), $urandom_range(1, 64), $urandom);
      random_items(100);
    end

    drain_wait();
    $display("covered %0d geometry settings: %0d writes, %0d requests (%0d letterbox)",
             n_phases, n_writes, n_reads, n_pads);
    $display("checked %0d answers, %0d mismatches", n_checked, mismatches);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lnbx_pkg.sv
hdl/lnbx_ram.sv
hdl/lnbx_geom.sv
hdl/lnbx_div2.sv
hdl/letterbox_nearest_scaler_unit.sv
tb/letterbox_nearest_scaler_unit_tb.sv
